### hw/rtl/prad_pkg.sv
package prad_pkg;

  localparam logic [1:0] KIND_CLEAR  = 2'd0;
  localparam logic [1:0] KIND_RULE   = 2'd1;
  localparam logic [1:0] KIND_PATH   = 2'd2;
  localparam logic [1:0] KIND_IGNORE = 2'd3;

  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_DOLLAR = 8'h24;

  localparam int unsigned WIN_W = 7;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_META,
    ST_MWAIT,
    ST_LOOP,
    ST_CMP,
    ST_TAIL,
    ST_TCMP,
    ST_DCMP,
    ST_NEXT,
    ST_DONE
  } state_e;

endpackage

### hw/rtl/prad_if.sv
interface prad_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] data_byte;
  logic       rule_is_allow;
  logic       last_byte;

  modport source (output valid, kind, data_byte, rule_is_allow, last_byte, input ready);
  modport sink   (input valid, kind, data_byte, rule_is_allow, last_byte, output ready);
endinterface

interface prad_out_if;
  logic                         valid;
  logic                         ready;
  logic                         allowed;
  logic                         allow_hit;
  logic                         disallow_hit;
  logic [prad_pkg::WIN_W-1:0]   winning_length;
  logic                         overflow;

  modport source (output valid, allowed, allow_hit, disallow_hit, winning_length, overflow,
                  input ready);
  modport sink   (input valid, allowed, allow_hit, disallow_hit, winning_length, overflow,
                  output ready);
endinterface

### hw/rtl/prad_ram.sv
module prad_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### hw/rtl/path_rule_allow_decider.sv
// Channel  Dir  Transfer payload
// req_i    in   kind, data_byte, rule_is_allow, last_byte
// rsp_o    out  allowed, allow_hit, disallow_hit, winning_length, overflow
//
// Clear, rule and path bytes are taken one per cycle while no match is running.
// The final path byte starts a rule walk: per rule a metadata fetch and bookkeeping step,
// a comparison per character and, unless a mismatch ends it early, a tail check, a step
// per trailing '*' and an end-anchor check; a final state hands the result over.
// Reset is asynchronous, active low; memory contents are undefined until written.
// A result waits in an output register while new bytes are taken; the next walk holds there.
module path_rule_allow_decider #(
  parameter int unsigned MAX_RULES    = 64,
  parameter int unsigned MAX_RULE_LEN = 64,
  parameter int unsigned MAX_PATH_LEN = 256
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  prad_in_if.sink    req_i,
  prad_out_if.source rsp_o
);

  localparam int unsigned RCW  = $clog2(MAX_RULES + 1);
  localparam int unsigned RIW  = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
  localparam int unsigned LENW = $clog2(MAX_RULE_LEN + 1);
  localparam int unsigned PLW  = $clog2(MAX_PATH_LEN + 1);
  localparam int unsigned PAW  = (MAX_PATH_LEN > 1) ? $clog2(MAX_PATH_LEN) : 1;
  localparam int unsigned TDEP = MAX_RULES * MAX_RULE_LEN;
  localparam int unsigned TAW  = (TDEP > 1) ? $clog2(TDEP) : 1;

  prad_pkg::state_e state_q, state_d;

  logic [RCW-1:0]  count_q, count_d;
  logic [LENW-1:0] pend_q, pend_d;
  logic [TAW-1:0]  wbase_q, wbase_d;
  logic [PLW-1:0]  plen_q, plen_d;
  logic            ovf_q, ovf_d;

  logic [RCW-1:0]  idx_q, idx_d;
  logic [TAW-1:0]  rbase_q, rbase_d;
  logic [LENW-1:0] rlen_q, rlen_d;
  logic            rtype_q, rtype_d;
  logic [LENW-1:0] r_q, r_d, sr_q, sr_d;
  logic [PLW-1:0]  p_q, p_d, sp_q, sp_d;
  logic            star_q, star_d;
  logic [LENW-1:0] long0_q, long0_d, long1_q, long1_d;
  logic            hit0_q, hit0_d, hit1_q, hit1_d;

  logic                     ov_q;
  logic                     o_allowed_q, o_ahit_q, o_dhit_q, o_ovf_q;
  logic [prad_pkg::WIN_W-1:0] o_win_q;

  logic accept;
  logic out_free;

  logic            txt_we, pth_we, met_we;
  logic [TAW-1:0]  txt_waddr, txt_raddr;
  logic [PAW-1:0]  pth_raddr;
  logic [7:0]      txt_rd, pth_rd;
  logic [LENW:0]   met_rd;

  logic            sm_eq, sm_skip, final_allowed;
  logic [LENW-1:0] final_win;

  assign req_i.ready = (state_q == prad_pkg::ST_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign out_free    = !ov_q || rsp_o.ready;

  assign sm_eq   = (txt_rd == pth_rd);
  assign sm_skip = met_rd[LENW] ? (long1_q > met_rd[LENW-1:0]) : (long0_q > met_rd[LENW-1:0]);

  assign final_allowed = !hit0_q || (hit1_q && (long1_q >= long0_q));
  assign final_win     = !final_allowed ? long0_q : (hit1_q ? long1_q : '0);

  // Write side of the memories: loading only happens on accepted bytes.
  assign txt_we    = accept && (req_i.kind == prad_pkg::KIND_RULE) &&
                     (count_q < RCW'(MAX_RULES)) && (pend_q < LENW'(MAX_RULE_LEN));
  assign txt_waddr = wbase_q + TAW'(pend_q);
  assign met_we    = accept && (req_i.kind == prad_pkg::KIND_RULE) &&
                     (count_q < RCW'(MAX_RULES)) && req_i.last_byte;
  assign pth_we    = accept && (req_i.kind == prad_pkg::KIND_PATH) &&
                     (plen_q < PLW'(MAX_PATH_LEN));

  always_comb begin
    txt_raddr = rbase_q + TAW'(r_q);
    pth_raddr = p_q[PAW-1:0];
    case (state_q)
      prad_pkg::ST_TCMP: begin
        txt_raddr = rbase_q + TAW'(r_q) - TAW'(1);
        pth_raddr = PAW'(p_q - PLW'(1));
      end
      default: ;
    endcase
  end

  prad_ram #(.WIDTH(8), .DEPTH(TDEP)) u_text (
    .clk_i, .we_i(txt_we), .waddr_i(txt_waddr), .wdata_i(req_i.data_byte),
    .raddr_i(txt_raddr), .rdata_o(txt_rd)
  );

  prad_ram #(.WIDTH(8), .DEPTH(MAX_PATH_LEN)) u_path (
    .clk_i, .we_i(pth_we), .waddr_i(plen_q[PAW-1:0]), .wdata_i(req_i.data_byte),
    .raddr_i(pth_raddr), .rdata_o(pth_rd)
  );

  prad_ram #(.WIDTH(LENW + 1), .DEPTH(MAX_RULES)) u_meta (
    .clk_i, .we_i(met_we), .waddr_i(count_q[RIW-1:0]),
    .wdata_i({req_i.rule_is_allow, txt_we ? LENW'(pend_q + LENW'(1)) : pend_q}),
    .raddr_i(idx_q[RIW-1:0]), .rdata_o(met_rd)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      prad_pkg::ST_IDLE: begin
        if (accept && (req_i.kind == prad_pkg::KIND_PATH) && req_i.last_byte) begin
          state_d = (count_q == '0) ? prad_pkg::ST_DONE : prad_pkg::ST_META;
        end
      end
      prad_pkg::ST_META:  state_d = prad_pkg::ST_MWAIT;
      prad_pkg::ST_MWAIT: state_d = sm_skip ? prad_pkg::ST_NEXT : prad_pkg::ST_LOOP;
      prad_pkg::ST_LOOP: begin
        state_d = ((p_q < plen_q) && (r_q < rlen_q)) ? prad_pkg::ST_CMP : prad_pkg::ST_TAIL;
      end
      prad_pkg::ST_CMP: begin
        if (!sm_eq && (txt_rd != prad_pkg::CH_STAR) && !star_q) begin
          state_d = prad_pkg::ST_NEXT;
        end else begin
          state_d = prad_pkg::ST_LOOP;
        end
      end
      prad_pkg::ST_TAIL: state_d = (r_q == rlen_q) ? prad_pkg::ST_NEXT : prad_pkg::ST_TCMP;
      prad_pkg::ST_TCMP: begin
        if (txt_rd == prad_pkg::CH_STAR) begin
          state_d = prad_pkg::ST_TAIL;
        end else if ((txt_rd == prad_pkg::CH_DOLLAR) && ({1'b0, r_q} + 1'b1 == {1'b0, rlen_q})
                     && (p_q == plen_q) && (r_q != '0) && (p_q != '0)) begin
          state_d = prad_pkg::ST_DCMP;
        end else begin
          state_d = prad_pkg::ST_NEXT;
        end
      end
      prad_pkg::ST_DCMP: state_d = prad_pkg::ST_NEXT;
      prad_pkg::ST_NEXT: begin
        state_d = (idx_q + RCW'(1) == count_q) ? prad_pkg::ST_DONE : prad_pkg::ST_META;
      end
      prad_pkg::ST_DONE: if (out_free) state_d = prad_pkg::ST_IDLE;
      default: state_d = prad_pkg::ST_IDLE;
    endcase
  end

  // Datapath updates.
  always_comb begin
    logic hit_now;
    hit_now  = 1'b0;
    count_d  = count_q;
    pend_d   = pend_q;
    wbase_d  = wbase_q;
    plen_d   = plen_q;
    ovf_d    = ovf_q;
    idx_d    = idx_q;
    rbase_d  = rbase_q;
    rlen_d   = rlen_q;
    rtype_d  = rtype_q;
    r_d      = r_q;
    sr_d     = sr_q;
    p_d      = p_q;
    sp_d     = sp_q;
    star_d   = star_q;
    long0_d  = long0_q;
    long1_d  = long1_q;
    hit0_d   = hit0_q;
    hit1_d   = hit1_q;
    case (state_q)
      prad_pkg::ST_IDLE: begin
        if (accept) begin
          case (req_i.kind)
            prad_pkg::KIND_CLEAR: begin
              count_d = '0;
              pend_d  = '0;
              wbase_d = '0;
              plen_d  = '0;
              ovf_d   = 1'b0;
            end
            prad_pkg::KIND_RULE: begin
              if (count_q >= RCW'(MAX_RULES)) begin
                ovf_d = 1'b1;
              end else begin
                if (txt_we) pend_d = pend_q + LENW'(1);
                else        ovf_d  = 1'b1;
                if (req_i.last_byte) begin
                  count_d = count_q + RCW'(1);
                  wbase_d = wbase_q + TAW'(MAX_RULE_LEN);
                  pend_d  = '0;
                end
              end
            end
            prad_pkg::KIND_PATH: begin
              if (pth_we) plen_d = plen_q + PLW'(1);
              else        ovf_d  = 1'b1;
              if (req_i.last_byte) begin
                idx_d   = '0;
                rbase_d = '0;
                long0_d = '0;
                long1_d = '0;
                hit0_d  = 1'b0;
                hit1_d  = 1'b0;
              end
            end
            default: ;
          endcase
        end
      end
      prad_pkg::ST_MWAIT: begin
        rlen_d  = met_rd[LENW-1:0];
        rtype_d = met_rd[LENW];
        r_d     = '0;
        p_d     = '0;
        star_d  = 1'b0;
      end
      prad_pkg::ST_CMP: begin
        if (sm_eq) begin
          p_d = p_q + PLW'(1);
          r_d = r_q + LENW'(1);
        end else if (txt_rd == prad_pkg::CH_STAR) begin
          star_d = 1'b1;
          sr_d   = r_q;
          sp_d   = p_q;
          r_d    = r_q + LENW'(1);
        end else if (star_q) begin
          r_d  = sr_q + LENW'(1);
          sp_d = sp_q + PLW'(1);
          p_d  = sp_q + PLW'(1);
        end
      end
      prad_pkg::ST_TAIL: hit_now = (r_q == rlen_q);
      prad_pkg::ST_TCMP: if (txt_rd == prad_pkg::CH_STAR) r_d = r_q + LENW'(1);
      prad_pkg::ST_DCMP: hit_now = sm_eq;
      prad_pkg::ST_NEXT: begin
        idx_d   = idx_q + RCW'(1);
        rbase_d = rbase_q + TAW'(MAX_RULE_LEN);
      end
      prad_pkg::ST_DONE: if (out_free) plen_d = '0;
      default: ;
    endcase
    if (hit_now) begin
      if (rtype_q) begin
        hit1_d  = 1'b1;
        long1_d = rlen_q;
      end else begin
        hit0_d  = 1'b1;
        long0_d = rlen_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= prad_pkg::ST_IDLE;
      count_q <= '0;
      pend_q  <= '0;
      wbase_q <= '0;
      plen_q  <= '0;
      ovf_q   <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      pend_q  <= pend_d;
      wbase_q <= wbase_d;
      plen_q  <= plen_d;
      ovf_q   <= ovf_d;
      if ((state_q == prad_pkg::ST_DONE) && out_free) ov_q <= 1'b1;
      else if (rsp_o.ready)                           ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    rbase_q <= rbase_d;
    rlen_q  <= rlen_d;
    rtype_q <= rtype_d;
    r_q     <= r_d;
    sr_q    <= sr_d;
    p_q     <= p_d;
    sp_q    <= sp_d;
    star_q  <= star_d;
    long0_q <= long0_d;
    long1_q <= long1_d;
    hit0_q  <= hit0_d;
    hit1_q  <= hit1_d;
    if ((state_q == prad_pkg::ST_DONE) && out_free) begin
      o_allowed_q <= final_allowed;
      o_ahit_q    <= hit1_q;
      o_dhit_q    <= hit0_q;
      o_win_q     <= prad_pkg::WIN_W'(final_win);
      o_ovf_q     <= ovf_q;
    end
  end

  assign rsp_o.valid          = ov_q;
  assign rsp_o.allowed        = o_allowed_q;
  assign rsp_o.allow_hit      = o_ahit_q;
  assign rsp_o.disallow_hit   = o_dhit_q;
  assign rsp_o.winning_length = o_win_q;
  assign rsp_o.overflow       = o_ovf_q;

  a_cmp_after_loop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == prad_pkg::ST_CMP |-> $past(state_q) == prad_pkg::ST_LOOP)
    else $error("comparison without a preceding read");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= RCW'(MAX_RULES))
    else $error("rule count beyond table size");

  a_loop_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == prad_pkg::ST_LOOP |-> (r_q <= rlen_q) && (p_q <= plen_q))
    else $error("match cursor beyond its string");

  a_busy_no_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != prad_pkg::ST_IDLE |-> !req_i.ready)
    else $error("input taken during rule walk");

endmodule

### test/prad_checker.sv
`timescale 1ns / 100ps

module prad_checker #(
  parameter int unsigned MAX_RULES    = 64,
  parameter int unsigned MAX_RULE_LEN = 64,
  parameter int unsigned MAX_PATH_LEN = 256
) (
  input  logic clk_i,
  input  logic rst_ni,
  prad_in_if   req_mon,
  prad_out_if  rsp_mon,
  output int   fail_count_o,
  output int   pending_o,
  output int   decisions_o
);

  typedef struct packed {
    logic           allowed;
    logic           allow_hit;
    logic           disallow_hit;
    logic [prad_pkg::WIN_W-1:0] winning_length;
    logic           overflow;
  } decision_t;

  logic [7:0] rule_mem [MAX_RULES][MAX_RULE_LEN];
  int         rule_len [MAX_RULES];
  bit         rule_allow [MAX_RULES];
  int         n_rules;
  int         open_len;
  logic [7:0] path_mem [MAX_PATH_LEN];
  int         path_len;
  bit         sticky_ovf;
  decision_t  decisions_q [$];
  int         fails;
  int         seen;

  assign fail_count_o = fails;
  assign pending_o    = decisions_q.size();
  assign decisions_o  = seen;

  // Literal match with '*' wildcards and a '$' end anchor, backtracking to the latest star only.
  function automatic bit rule_matches(int idx);
    int p, r, sr, sp;
    bit have_star;
    p = 0; r = 0; sr = 0; sp = 0; have_star = 0;
    while (p < path_len && r < rule_len[idx]) begin
      if (rule_mem[idx][r] == path_mem[p]) begin
        p++; r++;
      end else if (rule_mem[idx][r] == prad_pkg::CH_STAR) begin
        have_star = 1; sr = r; sp = p; r++;
      end else if (have_star) begin
        r = sr + 1; sp++; p = sp;
      end else begin
        return 0;
      end
    end
    while (r < rule_len[idx] && rule_mem[idx][r] == prad_pkg::CH_STAR) r++;
    if (r == rule_len[idx]) return 1;
    if (rule_mem[idx][r] == prad_pkg::CH_DOLLAR && r + 1 == rule_len[idx] && p == path_len &&
        r > 0 && p > 0 && rule_mem[idx][r-1] == path_mem[p-1]) return 1;
    return 0;
  endfunction

  function automatic decision_t decide_path();
    decision_t d;
    int  longest [2];
    bit  hit [2];
    int  t;
    longest[0] = 0; longest[1] = 0; hit[0] = 0; hit[1] = 0;
    for (int i = 0; i < n_rules; i++) begin
      t = int'(rule_allow[i]);
      if (longest[t] > rule_len[i]) continue;
      if (rule_matches(i)) begin
        hit[t] = 1;
        longest[t] = rule_len[i];
      end
    end
    d.allowed        = !hit[0] || (hit[1] && longest[1] >= longest[0]);
    d.allow_hit      = hit[1];
    d.disallow_hit   = hit[0];
    d.winning_length = prad_pkg::WIN_W'(!d.allowed ? longest[0] :
                                        (hit[1] ? longest[1] : 0));
    d.overflow       = sticky_ovf;
    return d;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    decision_t exp_d, got_d;
    if (!rst_ni) begin
      n_rules = 0; open_len = 0; path_len = 0; sticky_ovf = 0;
      decisions_q.delete();
      fails = 0; seen = 0;
    end else begin
      if (req_mon.valid && req_mon.ready) begin
        case (req_mon.kind)
          prad_pkg::KIND_CLEAR: begin
            n_rules = 0; open_len = 0; path_len = 0; sticky_ovf = 0;
          end
          prad_pkg::KIND_RULE: begin
            if (n_rules >= MAX_RULES) begin
              sticky_ovf = 1;
            end else begin
              if (open_len < MAX_RULE_LEN) begin
                rule_mem[n_rules][open_len] = req_mon.data_byte;
                open_len++;
              end else begin
                sticky_ovf = 1;
              end
              if (req_mon.last_byte) begin
                rule_len[n_rules]   = open_len;
                rule_allow[n_rules] = req_mon.rule_is_allow;
                n_rules++;
                open_len = 0;
              end
            end
          end
          prad_pkg::KIND_PATH: begin
            if (path_len < MAX_PATH_LEN) begin
              path_mem[path_len] = req_mon.data_byte;
              path_len++;
            end else begin
              sticky_ovf = 1;
            end
            if (req_mon.last_byte) begin
              decisions_q.push_back(decide_path());
              path_len = 0;
            end
          end
          default: ;
        endcase
      end
      if (rsp_mon.valid && rsp_mon.ready) begin
        got_d = '{rsp_mon.allowed, rsp_mon.allow_hit, rsp_mon.disallow_hit,
                  rsp_mon.winning_length, rsp_mon.overflow};
        seen++;
        if (decisions_q.size() == 0) begin
          fails++;
          if (fails <= 10) $display("unexpected result transfer: got %p", got_d);
        end else begin
          exp_d = decisions_q.pop_front();
          if (got_d !== exp_d) begin
            fails++;
            if (fails <= 10) $display("mismatch on decision %0d: expected %p, got %p",
                                      seen, exp_d, got_d);
          end
        end
      end
    end
  end
endmodule

### test/testbench.sv
`timescale 1ns / 100ps

module testbench;

  logic clk_i = 0;
  logic rst_ni = 0;
  int   fail_count, pending, decisions;
  int   sent;
  bit   calm;
  bit   squeeze;

  prad_in_if  req_if ();
  prad_out_if rsp_if ();

  path_rule_allow_decider u_top (.clk_i(clk_i), .rst_ni(rst_ni), .req_i(req_if), .rsp_o(rsp_if));

  prad_checker u_checker (
    .clk_i(clk_i), .rst_ni(rst_ni), .req_mon(req_if), .rsp_mon(rsp_if),
    .fail_count_o(fail_count), .pending_o(pending), .decisions_o(decisions)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    req_if.valid = 0; req_if.kind = prad_pkg::KIND_CLEAR; req_if.data_byte = 0;
    req_if.rule_is_allow = 0; req_if.last_byte = 0;
    rsp_if.ready = 0;
  end

  initial begin
    #500ms;
    $display("FAIL");
    $finish;
  end

  // Receiver: random stall bursts, one long hold-off so the block backs up.
  initial begin
    int burst;
    int hold;
    bit held;
    burst = 0; held = 0; hold = 0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (squeeze && !held) begin
        held = 1;
        hold = 3000;
      end
      if (hold > 0) begin
        hold--;
        rsp_if.ready <= 0;
      end else if (calm) begin
        rsp_if.ready <= 1;
      end else if (burst > 0) begin
        burst--;
        rsp_if.ready <= 0;
      end else if ($urandom_range(7) == 0) begin
        burst = $urandom_range(16, 1) - 1;
        rsp_if.ready <= 0;
      end else begin
        rsp_if.ready <= 1;
      end
    end
  end

  task automatic send(logic [1:0] kind, logic [7:0] b, bit allow, bit last);
    bit took;
    if (!calm && $urandom_range(5) == 0) begin
      req_if.valid <= 0;
      repeat ($urandom_range(16, 1)) @(posedge clk_i);
    end
    req_if.valid <= 1;
    req_if.kind <= kind;
    req_if.data_byte <= b;
    req_if.rule_is_allow <= allow;
    req_if.last_byte <= last;
    do begin
      @(negedge clk_i);
      took = req_if.ready;
      @(posedge clk_i);
    end while (!took);
    sent++;
  endtask

  task automatic load_rule(string s, bit allow);
    for (int i = 0; i < s.len(); i++)
      send(prad_pkg::KIND_RULE, s[i], (i == s.len() - 1) ? allow : 1'($urandom_range(1)),
           i == s.len() - 1);
  endtask

  task automatic send_path(string s);
    for (int i = 0; i < s.len(); i++)
      send(prad_pkg::KIND_PATH, s[i], 1'($urandom_range(1)), i == s.len() - 1);
  endtask

  function automatic logic [7:0] pick_char();
    case ($urandom_range(9))
      0, 1, 2: return "/";
      3, 4:    return "a";
      5:       return "b";
      6:       return prad_pkg::CH_STAR;
      7:       return prad_pkg::CH_DOLLAR;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic string rand_text(int lo, int hi);
    string s;
    int n;
    s = "";
    n = $urandom_range(hi, lo);
    for (int i = 0; i < n; i++) s = {s, string'(pick_char())};
    return s;
  endfunction

  initial begin
    string long_s;
    int n;
    sent = 0; calm = 0; squeeze = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed: literal, wildcard, end anchor, tie, empty-compare anchor, byte extremes.
    send(prad_pkg::KIND_CLEAR, 0, 0, 0);
    load_rule("/a", 0);
    load_rule("/a/b", 1);
    load_rule("/*b$", 0);
    load_rule("/a**", 1);
    load_rule("$", 0);
    send_path("/a/b");
    send_path("/ab");
    send_path("/x");
    send(prad_pkg::KIND_PATH, 8'h00, 0, 0);
    send(prad_pkg::KIND_PATH, 8'hFF, 1, 1);
    send(prad_pkg::KIND_IGNORE, 8'hA5, 1, 1);
    send(prad_pkg::KIND_CLEAR, 8'hFF, 1, 1);
    long_s = "";
    for (int i = 0; i < 65; i++) long_s = {long_s, "a"};
    load_rule(long_s, 1);
    send_path(long_s.substr(0, 63));
    long_s = "";
    for (int i = 0; i < 257; i++) long_s = {long_s, "/"};
    send_path(long_s);
    send(prad_pkg::KIND_CLEAR, 0, 0, 0);
    for (int i = 0; i < 66; i++) send(prad_pkg::KIND_RULE, "/", i[0], 1);
    send_path("/q");

    while (sent < 1750) begin
      if (sent > 900 && !squeeze) squeeze = 1;
      if (sent > 1500) calm = 1;
      case ($urandom_range(9))
        0: send(2'($urandom_range(3)), 8'($urandom_range(255)), 1'($urandom_range(1)),
                1'($urandom_range(1)));
        1: begin
          send(prad_pkg::KIND_CLEAR, 8'($urandom_range(255)), 1'($urandom_range(1)),
               1'($urandom_range(1)));
          n = $urandom_range(8);
          repeat (n) load_rule(rand_text(1, 8), 1'($urandom_range(1)));
        end
        2: repeat ($urandom_range(3)) load_rule(rand_text(1, 8), 1'($urandom_range(1)));
        default: send_path(rand_text(1, 16));
      endcase
    end
    calm = 1;
    req_if.valid <= 0;
    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    $display("Sent %0d input transfers and checked %0d decisions, including table, rule", sent,
             decisions);
    $display("and path overflow, wildcards, end anchors and a long output stall.");
    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

### sim.f
hw/rtl/prad_pkg.sv
hw/rtl/prad_if.sv
hw/rtl/prad_ram.sv
hw/rtl/path_rule_allow_decider.sv
test/prad_checker.sv
test/testbench.sv
